// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared types and constants
// Transfer structs, action codes, character codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BLANK = 8'd32;

    localparam logic CFG_FILL_ATTR = 1'b0;
    localparam logic CFG_TAB_WIDTH = 1'b1;

    localparam logic [7:0] RST_FILL_ATTR = 8'd7;
    localparam logic [3:0] RST_TAB_WIDTH = 4'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_tcw_in;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_offset;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_tcw_out;

endpackage

`default_nettype wire

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: text screen engine with cell store and cursor
// Puts characters, reads cells and clears a ROWS x COLS character screen.
// ----------------------------------------------------------------------------
// Command channel: an item transfers on a rising edge with i_start high and
// o_busy low. o_busy stays high until the result has been produced.
// Result channel: o_done pulses for one cycle with o_result; the receiver
// cannot stall, so the result must be taken in that cycle.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 scroll fill attribute, 1 tab width) at once. Write it only while the
// block is idle; the block itself does not enforce this.
// Steps from transfer to o_done, one cell store port per cycle:
//   plain put             one cell write; a newline only moves the cursor
//   tab                   tab_width blank cell writes (zero width: none)
//   read                  address step, then a registered cell store read
//   clear                 one blank write to every cell
//   each scroll adds      row copy plus bottom row fill
// Throughput: o_busy drops with o_done, so the next command may transfer in
// the cycle that o_done is high.
// Reset homes the cursor and loads the register defaults; the cell store is
// not cleared, and a cell never written reads back undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    parameter int COLS = tcw_pkg::DEF_COLS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire tcw_pkg::t_tcw_in i_item,
    output logic                  o_done,
    output tcw_pkg::t_tcw_out     o_result,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [7:0]       i_cfg_wdata
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_CLEAR,
        S_RD_ADDR,
        S_RD_MEM,
        S_FINISH
    } t_state;

    t_state            r_state;
    tcw_pkg::t_tcw_in  r_item;
    tcw_pkg::t_tcw_out r_res;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [AW-1:0]     r_base;
    logic [AW-1:0]     r_scan;
    logic [3:0]        r_cnt;
    logic [7:0]        r_char;
    logic [7:0]        r_fill_attr;
    logic [3:0]        r_tab;
    logic              r_rd_ok;
    logic              r_done;
    logic              r_we;
    logic              r_wram;
    logic [AW-1:0]     r_wa;
    logic [15:0]       r_wd;

    logic [AW-1:0]     ram_raddr;
    logic [15:0]       ram_rdata;
    logic [15:0]       ram_wdata;
    logic [31:0]       cur_off;
    logic [31:0]       cur_row_w;
    logic [31:0]       cur_col_w;
    logic              rd_in_range;
    logic [31:0]       rd_addr;

    assign ram_raddr   = (r_state == S_SCROLL) ? r_scan + ROW_STEP : r_scan;
    assign ram_wdata   = r_wram ? ram_rdata : r_wd;
    assign cur_off     = 32'(r_base) + 32'(r_col);
    assign cur_row_w   = 32'(r_row);
    assign cur_col_w   = 32'(r_col);
    assign rd_in_range = (32'(r_item.read_row) < ROWS) && (32'(r_item.read_col) < COLS);
    assign rd_addr     = 32'(r_item.read_row) * COLS + 32'(r_item.read_col);

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_wa),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_fill_attr <= tcw_pkg::RST_FILL_ATTR;
            r_tab       <= tcw_pkg::RST_TAB_WIDTH;
            r_done      <= 1'b0;
            r_we        <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_we   <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tcw_pkg::CFG_FILL_ATTR: r_fill_attr <= i_cfg_wdata;
                    tcw_pkg::CFG_TAB_WIDTH: r_tab <= i_cfg_wdata[3:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_rd_ok <= 1'b0;
                        r_scan  <= '0;
                        case (i_item.action)
                            tcw_pkg::ACT_PUT: begin
                                if (i_item.char_code == tcw_pkg::CH_TAB) begin
                                    r_cnt   <= r_tab;
                                    r_char  <= tcw_pkg::CH_BLANK;
                                    r_state <= (r_tab == 4'd0) ? S_FINISH : S_PUT;
                                end else if (i_item.char_code == tcw_pkg::CH_LF ||
                                             i_item.char_code == tcw_pkg::CH_CR) begin
                                    r_cnt <= 4'd0;
                                    r_col <= '0;
                                    if (r_row == LAST_ROW) begin
                                        r_state <= S_SCROLL;
                                    end else begin
                                        r_row   <= r_row + RW'(1);
                                        r_base  <= r_base + ROW_STEP;
                                        r_state <= S_FINISH;
                                    end
                                end else begin
                                    r_cnt   <= 4'd1;
                                    r_char  <= i_item.char_code;
                                    r_state <= S_PUT;
                                end
                            end
                            tcw_pkg::ACT_READ:  r_state <= S_RD_ADDR;
                            tcw_pkg::ACT_CLEAR: r_state <= S_CLEAR;
                            default:            r_state <= S_FINISH;
                        endcase
                    end
                end

                S_PUT: begin
                    r_we   <= 1'b1;
                    r_wram <= 1'b0;
                    r_wa   <= r_base + AW'(r_col);
                    r_wd   <= {r_item.attr, r_char};
                    r_cnt  <= r_cnt - 4'd1;
                    if (r_col == LAST_COL) begin
                        r_col <= '0;
                        if (r_row == LAST_ROW) begin
                            r_scan  <= '0;
                            r_state <= S_SCROLL;
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_base  <= r_base + ROW_STEP;
                            r_state <= (r_cnt == 4'd1) ? S_FINISH : S_PUT;
                        end
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_state <= (r_cnt == 4'd1) ? S_FINISH : S_PUT;
                    end
                end

                S_SCROLL: begin
                    r_we   <= 1'b1;
                    r_wram <= (r_scan < COPY_END);
                    r_wa   <= r_scan;
                    r_wd   <= {r_fill_attr, tcw_pkg::CH_BLANK};
                    if (r_scan == LAST_CELL) begin
                        r_state <= (r_cnt == 4'd0) ? S_FINISH : S_PUT;
                    end else begin
                        r_scan <= r_scan + AW'(1);
                    end
                end

                S_CLEAR: begin
                    r_we   <= 1'b1;
                    r_wram <= 1'b0;
                    r_wa   <= r_scan;
                    r_wd   <= {r_item.attr, tcw_pkg::CH_BLANK};
                    if (r_scan == LAST_CELL) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_base  <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_scan <= r_scan + AW'(1);
                    end
                end

                S_RD_ADDR: begin
                    r_rd_ok <= rd_in_range;
                    r_scan  <= rd_addr[AW-1:0];
                    r_state <= S_RD_MEM;
                end

                S_RD_MEM: begin
                    r_state <= S_FINISH;
                end

                S_FINISH: begin
                    r_done              <= 1'b1;
                    r_res.cursor_row    <= cur_row_w[4:0];
                    r_res.cursor_col    <= cur_col_w[6:0];
                    r_res.cursor_offset <= cur_off[10:0];
                    r_res.cell_char     <= r_rd_ok ? ram_rdata[7:0] : 8'd0;
                    r_res.cell_attr     <= r_rd_ok ? ram_rdata[15:8] : 8'd0;
                    r_state             <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("command transfer did not raise busy");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= LAST_COL) && (r_row <= LAST_ROW))
        else $error("cursor outside the screen");

    a_base_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) == 32'(r_row) * COLS)
        else $error("row base out of step with cursor row");

endmodule

`default_nettype wire

// ===== src/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
